@@ rtl/gww_pkg.sv @@
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types and constants for the greedy word wrap block.
// ----------------------------------------------------------------------------
package gww_pkg;

	localparam int BYTE_W         = 8;
	localparam int WIDTH_W        = 6;
	localparam int MAX_WORD_DEF   = 60;

	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 6'd60;

	localparam logic [BYTE_W-1:0] CH_NL = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SP = 8'd32;

	localparam logic CMD_TEXT  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREFIX,
		ST_REPLAY,
		ST_TAIL
	} gww_state_t;

	// source of the byte loaded into the output register
	typedef enum logic [1:0] {
		SEL_PREFIX,
		SEL_WORD,
		SEL_NL
	} gww_sel_t;

	typedef struct packed {
		logic     accept;
		logic     emit;
		gww_sel_t sel;
	} gww_ctl_t;

	typedef struct packed {
		logic out_free;
		logic dec_send;
		logic dec_pre;
		logic dec_tail_nz;
		logic tail_nz;
		logic tail_one;
		logic rep_last;
	} gww_sts_t;

endpackage

@@ rtl/gww_in_if.sv @@
// ----------------------------------------------------------------------------
// gww_in_if
// Text input channel: command and byte with valid/ready.
// ----------------------------------------------------------------------------
interface gww_in_if import gww_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output cmd, output in_byte, input ready);
	modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

@@ rtl/gww_out_if.sv @@
// ----------------------------------------------------------------------------
// gww_out_if
// Wrapped output channel: one byte per transfer with last and error flag.
// ----------------------------------------------------------------------------
interface gww_out_if import gww_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;
	logic              word_too_long;

	modport source (output valid, output out_byte, output last, output word_too_long,
		input ready);
	modport sink   (input valid, input out_byte, input last, input word_too_long,
		output ready);
endinterface

@@ rtl/greedy_word_wrap.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap
// Greedy line breaker: buffers each word and sends it out after a space,
// newline or flush, on the current line when it fits, else on a new line.
// ----------------------------------------------------------------------------
//
//   channel      dir  handshake        payload
//   text         in   valid / ready    cmd, in_byte
//   wrapped      out  valid / ready    out_byte, last, word_too_long
//   line_width   in   write enable     line_width_wdata (6 bits)
//
// A word byte is taken with no output. A space, newline or flush that
// closes a word then sends the leading space or newline (when one is
// needed), then each word byte, read back from the word buffer, then any
// trailing newlines. Input is held off (ready low) while a prefix, word
// or trailing newline is being sent. Reset clears all line state and sets
// line_width to 60; the word buffer holds no reset value. Output stalls
// hold the sequencer in place; the output register lets the next item
// enter while the last transfer is still pending.
module greedy_word_wrap import gww_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               line_width_we,
	input  logic [WIDTH_W-1:0] line_width_wdata,
	gww_in_if.sink             text,
	gww_out_if.source          wrapped
);

	gww_ctl_t ctl;
	gww_sts_t sts;

	// sequencer: takes items in IDLE, then steps through the bytes to send
	gww_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// buffer, line counters and output register
	gww_datapath #(
		.MAX_WORD (MAX_WORD)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.line_width_we     (line_width_we),
		.line_width_wdata  (line_width_wdata),
		.in_cmd            (text.cmd),
		.in_byte           (text.in_byte),
		.ctl               (ctl),
		.sts               (sts),
		.out_ready         (wrapped.ready),
		.out_valid         (wrapped.valid),
		.out_byte          (wrapped.out_byte),
		.out_last          (wrapped.last),
		.out_word_too_long (wrapped.word_too_long)
	);

endmodule

@@ rtl/gww_datapath.sv @@
// ----------------------------------------------------------------------------
// gww_datapath
// Word buffer, line bookkeeping, job registers and output register.
// ----------------------------------------------------------------------------
module gww_datapath import gww_pkg::*; #(
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               line_width_we,
	input  logic [WIDTH_W-1:0] line_width_wdata,
	input  logic               in_cmd,
	input  logic [BYTE_W-1:0]  in_byte,
	input  gww_ctl_t           ctl,
	output gww_sts_t           sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               out_last,
	output logic               out_word_too_long
);

	localparam int LW = $clog2(MAX_WORD + 1);
	localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int FW = (LW > WIDTH_W) ? LW : WIDTH_W;
	localparam int SW = FW + 2;

	logic [WIDTH_W-1:0] width_q;
	logic [LW-1:0]      len_q;
	logic [FW-1:0]      fill_q;
	logic [1:0]         run_q;
	logic               para_q;
	logic               err_q;

	logic [BYTE_W-1:0]  mem [0:MAX_WORD-1];
	logic [BYTE_W-1:0]  rdata_q;
	logic [LW-1:0]      ptr_q;
	logic [LW-1:0]      ptr_d;

	logic [LW-1:0]      jlen_q;
	logic [BYTE_W-1:0]  pre_byte_q;
	logic [1:0]         tail_q;
	logic               jerr_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;
	logic               out_wtl_q;

	logic               is_flush, is_nl, is_sp, is_chr;
	logic               has_word, send, first, fits, too_long, blank, room;
	logic [SW-1:0]      sum;
	logic [FW-1:0]      fill_new;
	logic [1:0]         tail_new;
	logic [BYTE_W-1:0]  pre_byte;
	logic               rep_last;
	logic               emit_word, emit_nl;

	// decode the offered item against the current line state
	always_comb begin
		is_flush = (in_cmd == CMD_FLUSH);
		is_nl    = !is_flush && (in_byte == CH_NL);
		is_sp    = !is_flush && (in_byte == CH_SP);
		is_chr   = !is_flush && !is_nl && !is_sp;
		has_word = (len_q != '0);
		send     = has_word && (is_flush || is_sp || (is_nl && run_q == 2'd0));
		first    = !para_q || (fill_q == '0);
		sum      = SW'(fill_q) + SW'(1) + SW'(len_q);
		fits     = (sum <= SW'(width_q));
		too_long = (SW'(len_q) > SW'(width_q));
		pre_byte = fits ? CH_SP : CH_NL;
		fill_new = (first || !fits) ? FW'(len_q) : sum[FW-1:0];
		blank    = is_nl && (run_q == 2'd1) && para_q;
		room     = (len_q < LW'(MAX_WORD));
		if (is_flush) begin
			tail_new = 2'd1;
		end else if (blank) begin
			tail_new = 2'd2;
		end else begin
			tail_new = 2'd0;
		end
	end

	assign emit_word = ctl.emit && (ctl.sel == SEL_WORD);
	assign emit_nl   = ctl.emit && (ctl.sel == SEL_NL);
	assign rep_last  = (LW'(ptr_q + LW'(1)) == jlen_q);

	always_comb begin
		if (ctl.accept) begin
			ptr_d = '0;
		end else if (emit_word) begin
			ptr_d = ptr_q + LW'(1);
		end else begin
			ptr_d = ptr_q;
		end
	end

	always_comb begin
		sts.out_free    = !out_valid_q || out_ready;
		sts.dec_send    = send;
		sts.dec_pre     = send && !first;
		sts.dec_tail_nz = (tail_new != 2'd0);
		sts.tail_nz     = (tail_q != 2'd0);
		sts.tail_one    = (tail_q == 2'd1);
		sts.rep_last    = rep_last;
	end

	// line and paragraph state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= LINE_WIDTH_RESET;
			len_q   <= '0;
			fill_q  <= '0;
			run_q   <= 2'd0;
			para_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (line_width_we) begin
				width_q <= line_width_wdata;
			end
			if (ctl.accept) begin
				if (is_flush) begin
					len_q  <= '0;
					fill_q <= '0;
					run_q  <= 2'd0;
					para_q <= 1'b0;
					err_q  <= 1'b0;
				end else if (is_chr) begin
					run_q <= 2'd0;
					if (room) begin
						len_q <= len_q + LW'(1);
					end else begin
						err_q <= 1'b1;
					end
				end else begin
					len_q <= '0;
					if (send) begin
						fill_q <= fill_new;
						para_q <= 1'b1;
						if (too_long) begin
							err_q <= 1'b1;
						end
					end
					if (is_sp) begin
						run_q <= 2'd0;
					end else begin
						if (blank) begin
							fill_q <= '0;
							para_q <= 1'b0;
						end
						if (run_q != 2'd2) begin
							run_q <= run_q + 2'd1;
						end
					end
				end
			end
		end
	end

	// job registers: what the current item still has to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			tail_q <= 2'd0;
			jerr_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (ctl.accept) begin
				tail_q <= tail_new;
				jerr_q <= is_flush && (err_q || (send && too_long));
			end else if (emit_nl) begin
				tail_q <= tail_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			jlen_q     <= len_q;
			pre_byte_q <= pre_byte;
		end
	end

	// word buffer; the read register follows the replay pointer while it is within the buffer
	always_ff @(posedge clk) begin
		if (ctl.accept && is_chr && room) begin
			mem[len_q[AW-1:0]] <= in_byte;
		end
		if (ptr_d < LW'(MAX_WORD)) begin
			rdata_q <= mem[ptr_d[AW-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_wtl_q <= jerr_q;
			unique case (ctl.sel)
				SEL_PREFIX: begin
					out_byte_q <= pre_byte_q;
					out_last_q <= 1'b0;
				end
				SEL_WORD: begin
					out_byte_q <= rdata_q;
					out_last_q <= rep_last && (tail_q == 2'd0);
				end
				SEL_NL: begin
					out_byte_q <= CH_NL;
					out_last_q <= (tail_q == 2'd1);
				end
				default: begin
					out_byte_q <= CH_NL;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign out_byte          = out_byte_q;
	assign out_last          = out_last_q;
	assign out_word_too_long = out_wtl_q;

endmodule

@@ rtl/gww_ctrl.sv @@
// ----------------------------------------------------------------------------
// gww_ctrl
// Sequencer: accept, send prefix, replay word, send trailing newlines.
// ----------------------------------------------------------------------------
module gww_ctrl import gww_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  gww_sts_t sts,
	output gww_ctl_t ctl
);

	gww_state_t state_q;
	gww_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		ctl.accept = 1'b0;
		ctl.emit   = 1'b0;
		ctl.sel    = SEL_WORD;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid) begin
					if (sts.dec_send) begin
						state_d = sts.dec_pre ? ST_PREFIX : ST_REPLAY;
					end else if (sts.dec_tail_nz) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_PREFIX: begin
				ctl.sel  = SEL_PREFIX;
				ctl.emit = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				ctl.sel  = SEL_WORD;
				ctl.emit = sts.out_free;
				if (sts.out_free && sts.rep_last) begin
					state_d = sts.tail_nz ? ST_TAIL : ST_IDLE;
				end
			end
			ST_TAIL: begin
				ctl.sel  = SEL_NL;
				ctl.emit = sts.out_free;
				if (sts.out_free && sts.tail_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
